@@ rtl/knnv_pkg.sv @@
// Shared types and constants for the k-nearest-neighbor majority vote block.
`default_nettype none

package knnv_pkg;

  localparam int DIST_W      = 32;
  localparam int LABEL_W     = 4;
  localparam int K_W         = 5;
  localparam int LABEL_SLOTS = 16;
  localparam logic [K_W-1:0] K_RESET = 5'd1;

  // input beat: one stored example
  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [LABEL_W-1:0] class_label;
    logic               last_example;
  } in_beat_t;

  // result beat: outcome of one query
  typedef struct packed {
    logic [LABEL_W-1:0] predicted_label;
    logic               found;
    logic [K_W-1:0]     final_k;
  } out_beat_t;

  // one entry of the sorted neighbor list
  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [LABEL_W-1:0] label;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // result of the shared comparator
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_WR0,
    ST_VOTE_INIT,
    ST_VOTE_CNT,
    ST_VOTE_SCAN,
    ST_VOTE_DEC,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/knnv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module knnv_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/knnv_cmp.sv @@
// Shared unsigned magnitude comparator used by insertion and vote scan.
`default_nettype none

module knnv_cmp (
  input  wire logic [knnv_pkg::DIST_W-1:0] a,
  input  wire logic [knnv_pkg::DIST_W-1:0] b,
  output knnv_pkg::cmp_res_t               res
);

  always_comb begin
    res.gt = (a > b);
    res.eq = (a == b);
  end

endmodule

`default_nettype wire

@@ rtl/knn_topk_majority_vote.sv @@
// Top level: sorted k-nearest list with majority vote over a shared comparator.
`default_nettype none

// Takes one (distance, class_label) beat per stored example and keeps the k
// nearest in a list sorted by distance (ties keep arrival order) held in one
// RAM with a single read and a single write port. k is neighbor_count, capped
// at MAX_NEIGHBORS; it must be written through the cfg port only while the
// block is idle (the user's duty; the block does not enforce it) and resets
// to 1. An example is inserted by walking the list from its tail, one entry
// per cycle, past each stored entry with a larger distance. Labels at or
// above NUM_LABELS are not stored, nor is any beat while k is 0.
// A beat marked last_example runs the vote after its insertion: a setup
// step, a counting step for each of the n listed entries, then per vote pass
// a scan step per label slot (min(NUM_LABELS,16)) and, on a tie, a step to
// drop the last voter before the next pass; an empty list skips the counting
// and the scan. The done state hands the result to the output register once
// that is free. The list RAM port and the one comparator set this serial
// order; in_ready is low while any of this runs. A result waits in the output
// register while the next query starts; only the delivery of the following
// result waits for out_ready. The result carries found=0, label 0 and
// final_k 0 when no unique majority exists.
module knn_topk_majority_vote #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int NUM_LABELS    = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire knnv_pkg::in_beat_t        in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output knnv_pkg::out_beat_t            out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [knnv_pkg::K_W-1:0]  cfg_neighbor_count
);

  localparam int IDX_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int FILL_W = $clog2(MAX_NEIGHBORS + 1);
  localparam int CW     = (FILL_W > knnv_pkg::K_W) ? FILL_W : knnv_pkg::K_W;
  localparam int CNT_W  = FILL_W;
  localparam logic [CW-1:0] K_MAX = CW'(MAX_NEIGHBORS);
  localparam logic [knnv_pkg::LABEL_W-1:0] SCAN_LAST =
    knnv_pkg::LABEL_W'((NUM_LABELS < knnv_pkg::LABEL_SLOTS) ?
                       NUM_LABELS - 1 : knnv_pkg::LABEL_SLOTS - 1);

  // control state
  knnv_pkg::state_t state_r, state_nxt;
  logic [knnv_pkg::K_W-1:0] k_cfg_r;
  logic [CW-1:0]            fill_r;
  logic                     out_valid_r;
  knnv_pkg::out_beat_t      out_data_r;

  // current example
  logic [knnv_pkg::DIST_W-1:0]  dist_r;
  logic [knnv_pkg::LABEL_W-1:0] label_r;
  logic                         last_r;

  // insertion and vote counters
  logic [CW-1:0]                i_r;
  logic [CW-1:0]                ci_r;
  logic [CW-1:0]                n_r;
  logic [CW-1:0]                kk_r;
  logic [knnv_pkg::LABEL_W-1:0] scan_r;
  logic [CNT_W-1:0]             best_r;
  logic [knnv_pkg::LABEL_W-1:0] win_r;
  logic                         uniq_r;
  logic                         found_r;
  logic [CNT_W-1:0]             cnt_r [knnv_pkg::LABEL_SLOTS];

  // list RAM
  logic                         ram_we;
  logic [CW-1:0]                waddr_full;
  logic [CW-1:0]                raddr_full;
  knnv_pkg::entry_t             ram_wdata;
  logic [knnv_pkg::ENTRY_W-1:0] ram_rbits;
  knnv_pkg::entry_t             rd_entry;

  // shared comparator
  logic [knnv_pkg::DIST_W-1:0]  cmp_a;
  logic [knnv_pkg::DIST_W-1:0]  cmp_b;
  knnv_pkg::cmp_res_t           cmp_res;

  // helpers
  logic [CW-1:0]                eff_k;
  logic [CW-1:0]                fill_trim;
  logic [CW-1:0]                i_plus;
  logic                         ins_go;
  logic                         label_ok;
  knnv_pkg::entry_t             new_entry;
  logic [knnv_pkg::LABEL_W-1:0] cnt_addr;
  logic [CNT_W-1:0]             cnt_rd;
  logic                         take;
  logic                         tie;
  logic [CNT_W-1:0]             best_nxt;
  logic [knnv_pkg::LABEL_W-1:0] win_nxt;
  logic                         uniq_nxt;
  logic                         scan_last;
  logic                         out_free;
  logic                         accept;

  assign in_ready  = (state_r == knnv_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // effective k: neighbor_count capped at the list depth
  assign eff_k     = (CW'(k_cfg_r) > K_MAX) ? K_MAX : CW'(k_cfg_r);
  // cut the list to the current k before touching it
  assign fill_trim = (fill_r > eff_k) ? eff_k : fill_r;
  assign i_plus    = i_r + CW'(1);
  assign label_ok  = (32'(in_data.class_label) < NUM_LABELS);
  assign ins_go    = label_ok && (eff_k != '0);
  assign new_entry = '{distance: dist_r, label: label_r};
  assign rd_entry  = ram_rbits;

  knnv_ram #(
    .WIDTH (knnv_pkg::ENTRY_W),
    .DEPTH (MAX_NEIGHBORS)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_full[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (raddr_full[IDX_W-1:0]),
    .rdata (ram_rbits)
  );

  // count table has one read point: scan slot or label of the entry just read
  assign cnt_addr = (state_r == knnv_pkg::ST_VOTE_SCAN) ? scan_r : rd_entry.label;
  assign cnt_rd   = cnt_r[cnt_addr];

  // comparator serves distances during insertion, counts during the scan
  assign cmp_a = (state_r == knnv_pkg::ST_VOTE_SCAN) ? knnv_pkg::DIST_W'(cnt_rd)
                                                      : rd_entry.distance;
  assign cmp_b = (state_r == knnv_pkg::ST_VOTE_SCAN) ? knnv_pkg::DIST_W'(best_r)
                                                      : dist_r;

  knnv_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // one scan step: strictly larger count takes the lead, equal count spoils it
  assign take      = (cnt_rd != '0) && cmp_res.gt;
  assign tie       = (cnt_rd != '0) && cmp_res.eq;
  assign best_nxt  = take ? cnt_rd : best_r;
  assign win_nxt   = take ? scan_r : win_r;
  assign uniq_nxt  = take ? 1'b1 : (tie ? 1'b0 : uniq_r);
  assign scan_last = (scan_r == SCAN_LAST);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      knnv_pkg::ST_IDLE: begin
        if (accept) begin
          if (ins_go) begin
            state_nxt = (fill_trim == '0) ? knnv_pkg::ST_INS_WR0 : knnv_pkg::ST_INS_CMP;
          end else if (in_data.last_example) begin
            state_nxt = knnv_pkg::ST_VOTE_INIT;
          end
        end
      end
      knnv_pkg::ST_INS_CMP: begin
        if (cmp_res.gt) begin
          if (i_r == '0) begin
            state_nxt = knnv_pkg::ST_INS_WR0;
          end
        end else begin
          state_nxt = last_r ? knnv_pkg::ST_VOTE_INIT : knnv_pkg::ST_IDLE;
        end
      end
      knnv_pkg::ST_INS_WR0: begin
        state_nxt = last_r ? knnv_pkg::ST_VOTE_INIT : knnv_pkg::ST_IDLE;
      end
      knnv_pkg::ST_VOTE_INIT: begin
        state_nxt = (fill_r == '0) ? knnv_pkg::ST_DONE : knnv_pkg::ST_VOTE_CNT;
      end
      knnv_pkg::ST_VOTE_CNT: begin
        if ((ci_r + CW'(1)) >= n_r) begin
          state_nxt = knnv_pkg::ST_VOTE_SCAN;
        end
      end
      knnv_pkg::ST_VOTE_SCAN: begin
        if (scan_last) begin
          if (uniq_nxt || (n_r == CW'(1))) begin
            state_nxt = knnv_pkg::ST_DONE;
          end else begin
            state_nxt = knnv_pkg::ST_VOTE_DEC;
          end
        end
      end
      knnv_pkg::ST_VOTE_DEC: begin
        state_nxt = knnv_pkg::ST_VOTE_SCAN;
      end
      knnv_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = knnv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = knnv_pkg::ST_IDLE;
      end
    endcase
  end

  // list RAM controls
  always_comb begin
    ram_we     = 1'b0;
    waddr_full = '0;
    ram_wdata  = new_entry;
    raddr_full = '0;
    unique case (state_r)
      knnv_pkg::ST_IDLE: begin
        // fetch the tail entry of the trimmed list
        raddr_full = fill_trim - CW'(1);
      end
      knnv_pkg::ST_INS_CMP: begin
        // prefetch the next entry toward the head
        raddr_full = i_r - CW'(1);
        if (i_plus < eff_k) begin
          ram_we     = 1'b1;
          waddr_full = i_plus;
          // larger entry slides down one slot, else the new one lands here
          ram_wdata  = cmp_res.gt ? rd_entry : new_entry;
        end
      end
      knnv_pkg::ST_INS_WR0: begin
        ram_we = 1'b1;
      end
      knnv_pkg::ST_VOTE_INIT: begin
        raddr_full = '0;
      end
      knnv_pkg::ST_VOTE_CNT: begin
        raddr_full = ci_r + CW'(1);
      end
      knnv_pkg::ST_VOTE_SCAN: begin
        // entry that drops out if this pass ends in a tie
        raddr_full = n_r - CW'(1);
      end
      knnv_pkg::ST_VOTE_DEC,
      knnv_pkg::ST_DONE: begin
        raddr_full = '0;
      end
      default: begin
        raddr_full = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= knnv_pkg::ST_IDLE;
      k_cfg_r     <= knnv_pkg::K_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        k_cfg_r <= cfg_neighbor_count;
      end
      // present a finished result, else drop one that was taken
      if ((state_r == knnv_pkg::ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      priority case (1'b1)
        // an unstored beat leaves the list alone unless it closes the query
        accept && (label_ok || in_data.last_example): begin
          fill_r <= fill_trim;
        end
        (state_r == knnv_pkg::ST_INS_CMP) && !cmp_res.gt && (i_plus < eff_k)
          && (fill_r < eff_k): begin
          fill_r <= fill_r + CW'(1);
        end
        (state_r == knnv_pkg::ST_INS_WR0) && (fill_r < eff_k): begin
          fill_r <= fill_r + CW'(1);
        end
        (state_r == knnv_pkg::ST_DONE) && out_free: begin
          // clear the list for the next query
          fill_r <= '0;
        end
        default: begin
          fill_r <= fill_r;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      knnv_pkg::ST_IDLE: begin
        if (accept) begin
          dist_r  <= in_data.distance;
          label_r <= in_data.class_label;
          last_r  <= in_data.last_example;
          i_r     <= fill_trim - CW'(1);
        end
      end
      knnv_pkg::ST_INS_CMP: begin
        i_r <= i_r - CW'(1);
      end
      knnv_pkg::ST_INS_WR0: begin
        i_r <= '0;
      end
      knnv_pkg::ST_VOTE_INIT: begin
        for (int s = 0; s < knnv_pkg::LABEL_SLOTS; s++) begin
          cnt_r[s] <= '0;
        end
        kk_r    <= eff_k;
        n_r     <= fill_r;
        ci_r    <= '0;
        found_r <= 1'b0;
      end
      knnv_pkg::ST_VOTE_CNT: begin
        cnt_r[cnt_addr] <= cnt_rd + CNT_W'(1);
        ci_r   <= ci_r + CW'(1);
        scan_r <= '0;
        best_r <= '0;
        win_r  <= '0;
        uniq_r <= 1'b0;
      end
      knnv_pkg::ST_VOTE_SCAN: begin
        best_r <= best_nxt;
        win_r  <= win_nxt;
        uniq_r <= uniq_nxt;
        scan_r <= scan_r + knnv_pkg::LABEL_W'(1);
        if (scan_last) begin
          if (uniq_nxt) begin
            found_r <= 1'b1;
          end else if (n_r != CW'(1)) begin
            // tie: shorten the prefix by one voter and try again
            kk_r <= n_r - CW'(1);
            n_r  <= n_r - CW'(1);
          end
        end
      end
      knnv_pkg::ST_VOTE_DEC: begin
        cnt_r[cnt_addr] <= cnt_rd - CNT_W'(1);
        scan_r <= '0;
        best_r <= '0;
        win_r  <= '0;
        uniq_r <= 1'b0;
      end
      knnv_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_r.found           <= found_r;
          out_data_r.predicted_label <= found_r ? win_r : '0;
          out_data_r.final_k         <= found_r ? knnv_pkg::K_W'(kk_r) : '0;
        end
      end
      default: begin
        i_r <= i_r;
      end
    endcase
  end

  // list never holds more than k entries while a beat is being worked on
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != knnv_pkg::ST_IDLE) |-> (fill_r <= eff_k))
    else $error("list fill exceeds k");

  // counting pass stays inside the voting prefix
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == knnv_pkg::ST_VOTE_CNT) |-> (ci_r < n_r))
    else $error("count index past prefix");

  // a found result always carries a nonzero k no larger than the configured k
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == knnv_pkg::ST_DONE) && found_r) |-> ((kk_r != '0) && (kk_r <= eff_k)))
    else $error("found vote with bad k");

  // delivering a result empties the list and raises out_valid
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == knnv_pkg::ST_DONE) && out_free) |=> (out_valid_r && (fill_r == '0)))
    else $error("result hand-off did not clear list");

  // not-found results carry zero label and zero k
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |->
      ((out_data_r.predicted_label == '0) && (out_data_r.final_k == '0)))
    else $error("not-found result not zeroed");

endmodule

`default_nettype wire

@@ tb/knn_vote_tb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the k-nearest-neighbor vote block: list predictor and result checker.
package knn_vote_tb_pkg;
  import knnv_pkg::*;

  localparam int LIST_DEPTH  = 16;  // MAX_NEIGHBORS of the instance
  localparam int LABEL_COUNT = 16;  // NUM_LABELS of the instance

  class knn_vote_board;
    logic [DIST_W-1:0]  near_dist [LIST_DEPTH];
    logic [LABEL_W-1:0] near_label [LIST_DEPTH];
    int                 fill;
    logic [K_W-1:0]     k_reg;
    out_beat_t          expected_q [$];
    int                 mismatches;
    int                 results_seen;
    int                 found_count;

    function new();
      fill = 0;
      k_reg = K_RESET;
      mismatches = 0;
      results_seen = 0;
      found_count = 0;
    endfunction

    function void set_k(logic [K_W-1:0] v);
      k_reg = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // saturate k at the list depth
    function int voters();
      return (k_reg > LIST_DEPTH) ? LIST_DEPTH : int'(k_reg);
    endfunction

    function void insert_example(logic [DIST_W-1:0] d, logic [LABEL_W-1:0] l, int k);
      int pos;
      int top;
      if (fill > k) fill = k;
      if (k == 0) return;
      pos = fill;
      // place before the first strictly larger distance
      for (int i = 0; i < fill; i++)
        if (pos == fill && near_dist[i] > d) pos = i;
      if (pos >= k) return;
      top = (fill < k) ? fill : k - 1;
      for (int j = top; j > pos; j--) begin
        near_dist[j] = near_dist[j-1];
        near_label[j] = near_label[j-1];
      end
      near_dist[pos] = d;
      near_label[pos] = l;
      if (fill < k) fill++;
    endfunction

    function bit majority(int n, output logic [LABEL_W-1:0] winner);
      int tally [LABEL_COUNT];
      int best;
      bit unique_top;
      best = 0;
      unique_top = 0;
      winner = '0;
      foreach (tally[c]) tally[c] = 0;
      for (int i = 0; i < n; i++) tally[near_label[i]]++;
      for (int c = 0; c < LABEL_COUNT; c++) begin
        if (tally[c] > best) begin
          best = tally[c];
          winner = LABEL_W'(c);
          unique_top = 1'b1;
        end else if (best > 0 && tally[c] == best) begin
          unique_top = 1'b0;
        end
      end
      return unique_top;
    endfunction

    // every 4-bit label is below LABEL_COUNT, so each example is offered to the list
    function void note_input(in_beat_t b);
      int k;
      int n;
      logic [LABEL_W-1:0] w;
      out_beat_t res;
      k = voters();
      insert_example(b.distance, b.class_label, k);
      if (!b.last_example) return;
      if (fill > k) fill = k;
      res = '0;
      for (int kk = k; kk > 0 && !res.found; kk--) begin
        n = (kk < fill) ? kk : fill;
        if (n > 0 && majority(n, w)) begin
          res.predicted_label = w;
          res.found = 1'b1;
          res.final_k = K_W'(kk);
        end
      end
      fill = 0;
      expected_q = {expected_q, res};
    endfunction

    task report_mismatch(string what);
      $display("%0t: result %0d: %s", $time, results_seen, what);
      mismatches++;
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no query outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (want.found) found_count++;
      if (got.predicted_label !== want.predicted_label)
        report_mismatch($sformatf("predicted_label %0d, expected %0d",
                                  got.predicted_label, want.predicted_label));
      if (got.found !== want.found)
        report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
      if (got.final_k !== want.final_k)
        report_mismatch($sformatf("final_k %0d, expected %0d", got.final_k, want.final_k));
    endtask
  endclass

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top testbench: drives example beats and k settings into the vote block and scores results.
module testbench;
  import knnv_pkg::*;
  import knn_vote_tb_pkg::*;

  localparam int     RANDOM_ITEMS = 2000;
  localparam int     DRAIN_CYCLES = 320;      // worst insert plus a full tie-down vote
  localparam int     HOLD_CYCLES  = 600;
  localparam longint CYCLE_LIMIT  = 3_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_beat_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_beat_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [K_W-1:0]      cfg_neighbor_count = '0;

  knn_vote_board board;
  bit            gaps_on = 1'b1;   // random idling on both sides
  int            sent = 0;         // accepted example beats
  int            queries = 0;
  int            k_writes = 0;
  longint        cycle_count = 0;

  // hold-off request from the stimulus; the receiver process counts it out
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  knn_topk_majority_vote #(
    .MAX_NEIGHBORS(LIST_DEPTH),
    .NUM_LABELS(LABEL_COUNT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_neighbor_count(cfg_neighbor_count)
  );

  always #2 clk = ~clk;

  // Abort a hung run; the limit is several times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d results outstanding", cycle_count, board.pending());
      $display("[knn_topk_majority_vote] ERROR");
      $finish;
    end
  end

  // Receiver: score each accepted result beat, then pick ready for the next edge.
  // Sample before the edge's updates land, so the handshake is seen as the block saw it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      // hold off so the output register and then the input back up
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (gaps_on) begin
      out_ready <= ($urandom_range(99) >= 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one example beat and wait for its acceptance. Keep valid high from one beat
  // to the next; drop it only for an idle gap, so valid never gets two updates in a step.
  task automatic send_example(input logic [DIST_W-1:0] d, input logic [LABEL_W-1:0] l,
                              input bit last);
    in_beat_t b;
    b.distance = d;
    b.class_label = l;
    b.last_example = last;
    while (gaps_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    board.note_input(b);
    sent++;
    if (last) queries++;
  endtask

  // Write k only with the block idle: drain expected results, then let a possible
  // open insertion or vote finish before the write beat.
  task automatic write_neighbor_count(input logic [K_W-1:0] v);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_neighbor_count <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_k(v);
    k_writes++;
    cfg_valid <= 1'b0;
  endtask

  // One query of len examples with a distance style and a label style drawn per query;
  // close it with the last mark unless it is to stay open across a k change.
  task automatic send_query(input int len, input bit with_last);
    int dist_mode;
    int label_mode;
    logic [DIST_W-1:0] d;
    logic [LABEL_W-1:0] l;
    dist_mode = $urandom_range(9);
    label_mode = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      // small pools force distance ties and vote ties; full range sweeps every bit
      if (dist_mode < 4) d = $urandom_range(7);
      else if (dist_mode < 8) d = $urandom();
      else begin
        case ($urandom_range(2))
          0:       d = '0;
          1:       d = '1;
          default: d = $urandom_range(3);
        endcase
      end
      if (label_mode < 5) l = LABEL_W'($urandom_range(2));
      else if (label_mode < 8) l = LABEL_W'($urandom_range(15));
      else l = $urandom_range(1) ? 4'd15 : 4'd0;
      send_example(d, l, with_last && (i == len - 1));
    end
  endtask

  initial begin
    int start_random;
    int r;
    int eff_k;
    int nq;
    int len;
    bit pressed;
    logic [K_W-1:0] k_pick;
    board = new();
    pressed = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset k of one, top extremes of distance and label
    send_example('1, 4'd15, 1'b1);
    // zero k: nothing stored, empty list, not found
    write_neighbor_count(5'd0);
    send_example('0, 4'd0, 1'b1);
    // full k on a short list with equal distances kept in arrival order
    write_neighbor_count(5'd16);
    send_example(32'd5, 4'd3, 1'b0);
    send_example(32'd5, 4'd7, 1'b0);
    send_example(32'd5, 4'd3, 1'b0);
    send_example(32'd0, 4'd9, 1'b0);
    send_example('1, 4'd1, 1'b0);
    send_example(32'd5, 4'd7, 1'b1);
    // tied top count: lower k until one label leads
    write_neighbor_count(5'd4);
    send_example(32'd1, 4'd2, 1'b0);
    send_example(32'd2, 4'd5, 1'b0);
    send_example(32'd3, 4'd2, 1'b0);
    send_example(32'd4, 4'd5, 1'b1);
    // k above the list depth saturates
    write_neighbor_count(5'd31);
    send_example(32'd10, 4'd4, 1'b0);
    send_example(32'd10, 4'd4, 1'b1);
    // k lowered mid-query: trim the open list before the next insertion
    write_neighbor_count(5'd3);
    send_example(32'd7, 4'd1, 1'b0);
    send_example(32'd8, 4'd2, 1'b0);
    send_example(32'd9, 4'd3, 1'b0);
    write_neighbor_count(5'd1);
    send_example(32'd9, 4'd0, 1'b1);

    // Random phases: new k, a few closed queries, now and then one left open
    start_random = sent;
    while (sent < start_random + RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 5) k_pick = 5'd0;
      else if (r < 10) k_pick = 5'd16;
      else if (r < 14) k_pick = K_W'($urandom_range(17, 31));
      else if (r < 20) k_pick = 5'd1;
      else k_pick = K_W'($urandom_range(2, 15));
      write_neighbor_count(k_pick);
      eff_k = (k_pick > LIST_DEPTH) ? LIST_DEPTH : int'(k_pick);

      // run a long stretch without any idling on either side
      gaps_on = !(sent >= start_random + 600 && sent < start_random + 1000);
      nq = $urandom_range(1, 5);
      if (!pressed && sent >= start_random + 1400) begin
        // stall the receiver while a burst of queries keeps arriving
        hold_asks++;
        pressed = 1'b1;
        nq = 8;
      end
      repeat (nq) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 2 * eff_k + 2);
        send_query(len, 1'b1);
      end
      if ($urandom_range(9) == 0) send_query($urandom_range(1, 6), 1'b0);
    end

    // drain: close any open query so the list ends empty, then wait for every result
    send_example($urandom(), LABEL_W'($urandom_range(15)), 1'b1);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d examples in %0d queries over %0d k settings, k from 0 up to 31",
             sent, queries, k_writes + 1);
    $display("checked %0d results, %0d with a unique majority, %0d mismatches",
             board.results_seen, board.found_count, board.mismatches);
    if (board.mismatches == 0) begin
      $display("[knn_topk_majority_vote] OK");
    end else begin
      $display("[knn_topk_majority_vote] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/knnv_pkg.sv
rtl/knnv_ram.sv
rtl/knnv_cmp.sv
rtl/knn_topk_majority_vote.sv
tb/knn_vote_tb_pkg.sv
tb/testbench.sv
